// ===== hw/rtl/mdhfk_pkg.sv =====
// Shared types, constants and tables for the MDH forward kinematics core.
// No dependencies; used by the front, queue, back and top modules.
package mdhfk_pkg;

	localparam int NUM_JOINTS_DEF = 6;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CORDIC_STEPS   = 28;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int TRIG_W = 33;
	localparam int MAC_COUNT = 48;

	typedef enum logic [1:0] {
		REG_BASE_HEIGHT = 2'd0,
		REG_LINK_THREE  = 2'd1,
		REG_LINK_FIVE   = 2'd2,
		REG_LINK_SIX    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROT,
		BK_TRIG,
		BK_MAC,
		BK_DONE
	} bk_state_t;

	// one classified joint word handed from front to back
	typedef struct packed {
		logic              last;
		logic [2:0]        joint;
		logic [1:0]        quad;
		logic signed [13:0] resid;
	} jnt_word_t;

	function automatic logic [15:0] joint_offset(input logic [2:0] j);
		logic [15:0] v;
		case (j)
			3'd0: v = 16'd16384;
			3'd1: v = 16'd49152;
			3'd3: v = 16'd16384;
			3'd5: v = 16'd16384;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic logic cos_alpha(input logic [2:0] j);
		return (j == 3'd0) || (j == 3'd2) || (j == 3'd3);
	endfunction

	function automatic logic sin_alpha_pos(input logic [2:0] j);
		return (j == 3'd1) || (j == 3'd5);
	endfunction

	function automatic logic sin_alpha_neg(input logic [2:0] j);
		return (j == 3'd4);
	endfunction

	function automatic logic signed [32:0] cordic_atan(input logic [4:0] i);
		logic signed [32:0] v;
		case (i)
			5'd0:  v = 33'sd536870912;
			5'd1:  v = 33'sd316933406;
			5'd2:  v = 33'sd167458907;
			5'd3:  v = 33'sd85004756;
			5'd4:  v = 33'sd42667331;
			5'd5:  v = 33'sd21354465;
			5'd6:  v = 33'sd10679838;
			5'd7:  v = 33'sd5340245;
			5'd8:  v = 33'sd2670163;
			5'd9:  v = 33'sd1335087;
			5'd10: v = 33'sd667544;
			5'd11: v = 33'sd333772;
			5'd12: v = 33'sd166886;
			5'd13: v = 33'sd83443;
			5'd14: v = 33'sd41722;
			5'd15: v = 33'sd20861;
			5'd16: v = 33'sd10430;
			5'd17: v = 33'sd5215;
			5'd18: v = 33'sd2608;
			5'd19: v = 33'sd1304;
			5'd20: v = 33'sd652;
			5'd21: v = 33'sd326;
			5'd22: v = 33'sd163;
			5'd23: v = 33'sd81;
			5'd24: v = 33'sd41;
			5'd25: v = 33'sd20;
			5'd26: v = 33'sd10;
			5'd27: v = 33'sd5;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/mdhfk_front.sv =====
// Front end: accepts joint angles, tracks the joint count, adds the joint offset
// and splits the angle into quadrant and residual. Depends on mdhfk_pkg.
module mdhfk_front #(
	parameter int NUM_JOINTS = mdhfk_pkg::NUM_JOINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  joint_valid,
	output logic                  joint_ready,
	input  logic [15:0]           joint_angle,
	input  logic                  q_full,
	output logic                  q_push,
	output mdhfk_pkg::jnt_word_t  q_word
);
	import mdhfk_pkg::*;

	logic [2:0]  joint_q;
	logic [2:0]  jnt;
	logic [15:0] ang;
	logic [15:0] ang_rnd;
	logic [15:0] resid;
	logic        last;

	// out-of-range count acts as joint 0
	assign jnt     = (32'(joint_q) >= NUM_JOINTS) ? 3'd0 : joint_q;
	assign last    = (32'(jnt) + 1) >= NUM_JOINTS;
	assign ang     = joint_angle + joint_offset(jnt);
	assign ang_rnd = ang + 16'd8192;
	assign resid   = ang - {ang_rnd[15:14], 14'd0};

	assign joint_ready  = !q_full;
	assign q_push       = joint_valid && !q_full;
	assign q_word.last  = last;
	assign q_word.joint = jnt;
	assign q_word.quad  = ang_rnd[15:14];
	assign q_word.resid = resid[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_q <= 3'd0;
		end else if (q_push) begin
			joint_q <= last ? 3'd0 : jnt + 3'd1;
		end
	end

endmodule

// ===== hw/rtl/mdhfk_queue.sv =====
// Two-entry queue of classified joint words between front and back.
// Depends on mdhfk_pkg.
module mdhfk_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mdhfk_pkg::jnt_word_t  push_word,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output mdhfk_pkg::jnt_word_t  head
);
	import mdhfk_pkg::*;

	jnt_word_t  mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/mdhfk_back.sv =====
// Back end: iterative CORDIC for the joint residual (skipped when it is zero), then the pose times link
// transform product on one shared multiplier. Depends on mdhfk_pkg.
module mdhfk_back #(
	parameter int FRAC_BITS = mdhfk_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  mdhfk_pkg::jnt_word_t  q_head,
	output logic                  q_pop,
	input  logic [30:0]           base_height,
	input  logic [30:0]           link_three_length,
	input  logic [30:0]           link_five_length,
	input  logic [30:0]           link_six_offset,
	output logic                  pose_valid,
	input  logic                  pose_ready,
	output logic signed [31:0]    pose_out [12]
);
	import mdhfk_pkg::*;

	localparam int SH = 30 - FRAC_BITS;
	localparam logic signed [33:0] TRIG_HALF = 34'sd1 <<< (SH - 1);
	localparam logic signed [TRIG_W-1:0] ONE = TRIG_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [66:0] RND_HALF = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
	localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

	bk_state_t state_q, state_d;

	jnt_word_t                 ent_q;
	logic [4:0]                step_q;
	logic signed [33:0]        x_q, y_q;
	logic signed [32:0]        z_q;
	logic signed [TRIG_W-1:0]  ct_q, st_q;
	logic [5:0]                cnt_q;
	logic                      v_s1;
	logic signed [64:0]        prod_s1;
	logic [3:0]                e_s1;
	logic [1:0]                k_s1;
	logic signed [66:0]        acc_q;
	logic signed [31:0]        nxt_q  [12];
	logic signed [31:0]        pose_q [12];
	logic signed [31:0]        out_q  [12];
	logic                      out_valid_q;

	logic                      load_out;
	logic                      issue;
	logic signed [33:0]        xs, ys, xr, yr;
	logic signed [TRIG_W-1:0]  c0, s0, cq, sq;
	logic signed [TRIG_W-1:0]  a_len, d_len, t_sel;
	logic                      ca, sap, san;
	logic [1:0]                mr, mc, mk;
	logic signed [66:0]        acc_sum, rnd;
	logic signed [31:0]        sat;

	function automatic logic signed [TRIG_W-1:0] clamp_one(input logic signed [33:0] v);
		logic signed [TRIG_W-1:0] r;
		if (v > 34'(ONE)) begin
			r = ONE;
		end else if (v < -34'(ONE)) begin
			r = -ONE;
		end else begin
			r = v[TRIG_W-1:0];
		end
		return r;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (q_head.resid == 14'sd0) ? BK_TRIG : BK_ROT;
				end
			end
			BK_ROT: begin
				if (step_q == 5'(CORDIC_STEPS - 1)) begin
					state_d = BK_TRIG;
				end
			end
			BK_TRIG: state_d = BK_MAC;
			BK_MAC: begin
				if (cnt_q == 6'(MAC_COUNT) && !v_s1) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || pose_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// CORDIC rounding and quadrant fold
	assign xs = y_q >>> step_q;
	assign ys = x_q >>> step_q;
	assign xr = (x_q + TRIG_HALF) >>> SH;
	assign yr = (y_q + TRIG_HALF) >>> SH;
	assign c0 = (ent_q.resid == 14'sd0) ? ONE : clamp_one(xr);
	assign s0 = (ent_q.resid == 14'sd0) ? '0 : clamp_one(yr);

	always_comb begin
		case (ent_q.quad)
			2'd0: begin cq = c0;  sq = s0;  end
			2'd1: begin cq = -s0; sq = c0;  end
			2'd2: begin cq = -c0; sq = -s0; end
			default: begin cq = s0; sq = -c0; end
		endcase
	end

	// link transform element for the current product term
	assign ca  = cos_alpha(ent_q.joint);
	assign sap = sin_alpha_pos(ent_q.joint);
	assign san = sin_alpha_neg(ent_q.joint);
	assign mr  = cnt_q[5:4];
	assign mc  = cnt_q[3:2];
	assign mk  = cnt_q[1:0];

	always_comb begin
		a_len = '0;
		d_len = '0;
		case (ent_q.joint)
			3'd0: d_len = TRIG_W'(base_height);
			3'd2: a_len = -TRIG_W'(link_three_length);
			3'd3: begin
				a_len = -TRIG_W'(link_five_length);
				d_len = TRIG_W'(link_six_offset);
			end
			default: ;
		endcase
	end

	always_comb begin
		t_sel = '0;
		case ({mk, mc})
			4'b00_00: t_sel = ct_q;
			4'b00_01: t_sel = -st_q;
			4'b00_11: t_sel = a_len;
			4'b01_00: t_sel = ca ? st_q : '0;
			4'b01_01: t_sel = ca ? ct_q : '0;
			4'b01_10: t_sel = sap ? -ONE : (san ? ONE : '0);
			4'b01_11: t_sel = sap ? -d_len : (san ? d_len : '0);
			4'b10_00: t_sel = sap ? st_q : (san ? -st_q : '0);
			4'b10_01: t_sel = sap ? ct_q : (san ? -ct_q : '0);
			4'b10_10: t_sel = ca ? ONE : '0;
			4'b10_11: t_sel = ca ? d_len : '0;
			4'b11_11: t_sel = ONE;
			default:  t_sel = '0;
		endcase
	end

	assign issue   = (state_q == BK_MAC) && (cnt_q != 6'(MAC_COUNT));
	assign acc_sum = acc_q + 67'(prod_s1);
	assign rnd     = acc_sum >>> FRAC_BITS;
	assign sat     = (rnd > SAT_MAX) ? 32'sh7fffffff :
	                 (rnd < SAT_MIN) ? 32'sh80000000 : rnd[31:0];
	assign load_out = (state_q == BK_DONE) && (!out_valid_q || pose_ready);

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ent_q  <= q_head;
				step_q <= 5'd0;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= {{3{q_head.resid[13]}}, q_head.resid, 16'd0};
			end
			BK_ROT: begin
				step_q <= step_q + 5'd1;
				if (!z_q[32]) begin
					x_q <= x_q - xs;
					y_q <= y_q + ys;
					z_q <= z_q - cordic_atan(step_q);
				end else begin
					x_q <= x_q + xs;
					y_q <= y_q - ys;
					z_q <= z_q + cordic_atan(step_q);
				end
			end
			BK_TRIG: begin
				ct_q  <= cq;
				st_q  <= sq;
			end
			default: ;
		endcase
		// multiply stage
		prod_s1 <= pose_q[{mr, mk}] * t_sel;
		e_s1    <= {mr, mc};
		k_s1    <= mk;
		// accumulate stage
		if (v_s1) begin
			if (k_s1 == 2'd0) begin
				acc_q <= RND_HALF + 67'(prod_s1);
			end else begin
				acc_q <= acc_sum;
			end
			if (k_s1 == 2'd3) begin
				nxt_q[e_s1] <= sat;
			end
		end
		if (load_out) begin
			out_q <= nxt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 12; i++) begin
				pose_q[i] <= (i % 5 == 0) ? 32'(ONE) : 32'sd0;
			end
		end else begin
			v_s1 <= issue;
			if (state_q == BK_TRIG) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < 12; i++) begin
					// return to identity after the last joint
					if (ent_q.last) begin
						pose_q[i] <= (i % 5 == 0) ? 32'(ONE) : 32'sd0;
					end else begin
						pose_q[i] <= nxt_q[i];
					end
				end
			end else if (pose_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pose_valid = out_valid_q;
	assign pose_out   = out_q;

endmodule

// ===== hw/rtl/mdh_forward_kinematics_core.sv =====
// Flow: a joint word taken by the front passes the two-entry queue, is fetched by
// the back, rotated by the 28-step CORDIC (skipped for a zero residual), folded
// into its quadrant and run through 48 products on the single shared multiplier. The
// back takes one word at a time; the queue lets the front accept more until full.
// Reset: asynchronous, active low; pose to identity, joint count to zero,
// link registers to 0.6, 0.4, 0.2 and 0.1 in the fixed-point format.
module mdh_forward_kinematics_core #(
	parameter int NUM_JOINTS = mdhfk_pkg::NUM_JOINTS_DEF,
	parameter int FRAC_BITS  = mdhfk_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               joint_valid,
	output logic               joint_ready,
	input  logic [15:0]        joint_angle,
	output logic               pose_valid,
	input  logic               pose_ready,
	output logic signed [31:0] row0_col0,
	output logic signed [31:0] row0_col1,
	output logic signed [31:0] row0_col2,
	output logic signed [31:0] row0_col3,
	output logic signed [31:0] row1_col0,
	output logic signed [31:0] row1_col1,
	output logic signed [31:0] row1_col2,
	output logic signed [31:0] row1_col3,
	output logic signed [31:0] row2_col0,
	output logic signed [31:0] row2_col1,
	output logic signed [31:0] row2_col2,
	output logic signed [31:0] row2_col3
);
	import mdhfk_pkg::*;

	localparam logic [30:0] BASE_RST = 31'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [30:0] L3_RST   = 31'(((64'd4 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [30:0] L5_RST   = 31'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [30:0] L6_RST   = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

	logic [30:0]        base_height_q, link_three_q, link_five_q, link_six_q;
	logic               wr_en;
	reg_idx_t           reg_idx;
	logic               q_push, q_full, q_pop, q_empty;
	jnt_word_t          q_word, q_head;
	logic signed [31:0] pose_out [12];

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= BASE_RST;
			link_three_q  <= L3_RST;
			link_five_q   <= L5_RST;
			link_six_q    <= L6_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BASE_HEIGHT: base_height_q <= pwdata[30:0];
				REG_LINK_THREE:  link_three_q  <= pwdata[30:0];
				REG_LINK_FIVE:   link_five_q   <= pwdata[30:0];
				REG_LINK_SIX:    link_six_q    <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE_HEIGHT: prdata = {1'b0, base_height_q};
			REG_LINK_THREE:  prdata = {1'b0, link_three_q};
			REG_LINK_FIVE:   prdata = {1'b0, link_five_q};
			REG_LINK_SIX:    prdata = {1'b0, link_six_q};
			default:         prdata = '0;
		endcase
	end

	mdhfk_front #(.NUM_JOINTS(NUM_JOINTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.joint_valid (joint_valid),
		.joint_ready (joint_ready),
		.joint_angle (joint_angle),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_word      (q_word)
	);

	mdhfk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_word),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	mdhfk_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (q_pop),
		.base_height       (base_height_q),
		.link_three_length (link_three_q),
		.link_five_length  (link_five_q),
		.link_six_offset   (link_six_q),
		.pose_valid        (pose_valid),
		.pose_ready        (pose_ready),
		.pose_out          (pose_out)
	);

	assign row0_col0 = pose_out[0];
	assign row0_col1 = pose_out[1];
	assign row0_col2 = pose_out[2];
	assign row0_col3 = pose_out[3];
	assign row1_col0 = pose_out[4];
	assign row1_col1 = pose_out[5];
	assign row1_col2 = pose_out[6];
	assign row1_col3 = pose_out[7];
	assign row2_col0 = pose_out[8];
	assign row2_col1 = pose_out[9];
	assign row2_col2 = pose_out[10];
	assign row2_col3 = pose_out[11];

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for mdh_forward_kinematics_core: drives joint words,
// predicts each cumulative pose and checks every pose word.
// Depends on mdhfk_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
	import mdhfk_pkg::*;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 <<< FRAC;
	localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

	typedef logic [11:0][31:0] pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic joint_valid = 1'b0;
	logic joint_ready;
	logic [15:0] joint_angle = '0;
	logic pose_valid;
	logic pose_ready = 1'b0;
	logic signed [31:0] row0_col0, row0_col1, row0_col2, row0_col3;
	logic signed [31:0] row1_col0, row1_col1, row1_col2, row1_col3;
	logic signed [31:0] row2_col0, row2_col1, row2_col2, row2_col3;

	mdh_forward_kinematics_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [30:0] len_reg [4];
	longint pose_now [12];
	int joint_idx;

	logic [15:0] angle_q [$];
	pose_t pose_exp_q [$];
	int fail_cnt = 0;
	bit calm = 0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic longint clamp_unit(input longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic cordic_sincos(input logic [15:0] q, output longint co, output longint si);
		int unsigned quad;
		int r;
		longint c, s, x, y, z, dx, dy;
		quad = ((int'(q) + 8192) >> 14) & 3;
		r = (int'(q) - int'(quad) * 16384) & 16'hFFFF;
		if (r >= 32768) r -= 65536;
		if (r == 0) begin
			c = ONE;
			s = 0;
		end else begin
			x = 64'sd652032874;
			y = 0;
			z = longint'(r) * 65536;
			for (int i = 0; i < 28; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(cordic_atan(5'(i)));
				end else begin
					x += dx; y -= dy; z += longint'(cordic_atan(5'(i)));
				end
			end
			c = clamp_unit((x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
			s = clamp_unit((y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
		end
		case (quad)
			0: begin co = c; si = s; end
			1: begin co = -s; si = c; end
			2: begin co = -c; si = -s; end
			default: begin co = s; si = -c; end
		endcase
	endtask

	// advance the pose by one joint and queue the resulting word
	task automatic advance_pose(input logic [15:0] ang);
		longint ct, st, a, d, ca, sa, te, p, hi, lo;
		longint t [3][4];
		longint nxt [12];
		logic [15:0] q;
		pose_t w;
		int j;
		j = joint_idx;
		q = ang + joint_offset(3'(j));
		cordic_sincos(q, ct, st);
		ca = cos_alpha(3'(j)) ? 1 : 0;
		sa = sin_alpha_pos(3'(j)) ? 1 : (sin_alpha_neg(3'(j)) ? -1 : 0);
		a = 0;
		d = 0;
		if (j == 0) d = longint'(len_reg[REG_BASE_HEIGHT]);
		if (j == 2) a = -longint'(len_reg[REG_LINK_THREE]);
		if (j == 3) begin
			a = -longint'(len_reg[REG_LINK_FIVE]);
			d = longint'(len_reg[REG_LINK_SIX]);
		end
		t[0][0] = ct;      t[0][1] = -st;     t[0][2] = 0;        t[0][3] = a;
		t[1][0] = st * ca; t[1][1] = ct * ca; t[1][2] = -ONE * sa; t[1][3] = -d * sa;
		t[2][0] = st * sa; t[2][1] = ct * sa; t[2][2] = ONE * ca;  t[2][3] = d * ca;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++) begin
				hi = 0;
				lo = 0;
				for (int k = 0; k < 4; k++) begin
					te = (k < 3) ? t[k][c] : ((c == 3) ? ONE : 0);
					p = pose_now[r*4+k] * te;
					hi += p >>> FRAC;
					lo += p & (ONE - 1);
				end
				nxt[r*4+c] = sat32(hi + ((lo + (ONE >>> 1)) >>> FRAC));
			end
		for (int k = 0; k < 12; k++) begin
			pose_now[k] = nxt[k];
			w[k] = nxt[k][31:0];
		end
		pose_exp_q.push_back(w);
		if (j + 1 >= 6) begin
			reset_pose();
		end else begin
			joint_idx = j + 1;
		end
	endtask

	task automatic reset_pose();
		for (int k = 0; k < 12; k++) pose_now[k] = (k == 0 || k == 5 || k == 10) ? ONE : 0;
		joint_idx = 0;
	endtask

	// joint word driver
	always @(posedge clk or negedge arst_n) begin
		bit hold;
		if (!arst_n) begin
			joint_valid <= 1'b0;
			joint_angle <= '0;
		end else begin
			hold = joint_valid;
			if (joint_valid && joint_ready) begin
				advance_pose(joint_angle);
				hold = 0;
			end
			if (!hold) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (angle_q.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 12);
					end else begin
						joint_angle <= angle_q.pop_front();
						hold = 1;
					end
				end
			end
			joint_valid <= hold;
		end
	end

	// pose word monitor
	always @(posedge clk or negedge arst_n) begin
		pose_t got, want;
		bit rdy;
		if (!arst_n) begin
			pose_ready <= 1'b0;
		end else begin
			if (pose_valid && pose_ready) begin
				got = {row2_col3, row2_col2, row2_col1, row2_col0,
					row1_col3, row1_col2, row1_col1, row1_col0,
					row0_col3, row0_col2, row0_col1, row0_col0};
				if (pose_exp_q.size() == 0) begin
					$error("pose word with none expected");
					fail_cnt++;
				end else begin
					want = pose_exp_q.pop_front();
					for (int k = 0; k < 12; k++)
						if (got[k] !== want[k]) begin
							$error("row%0d_col%0d: expected %0d, got %0d", k / 4, k % 4,
								$signed(want[k]), $signed(got[k]));
							fail_cnt++;
						end
				end
			end
			rdy = 1;
			if (recv_gap > 0) begin
				recv_gap--;
				rdy = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 12);
				rdy = 0;
			end
			pose_ready <= rdy;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		len_reg[idx] = val[30:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [30:0] l1, l3, l5, l6);
		reg_write(REG_BASE_HEIGHT, {1'b0, l1});
		reg_write(REG_LINK_THREE, {1'b0, l3});
		reg_write(REG_LINK_FIVE, {1'b0, l5});
		reg_write(REG_LINK_SIX, {1'b0, l6});
	endtask

	// sample at the falling edge, once the driver's updates have settled
	task automatic drain();
		do begin
			@(negedge clk);
		end while (angle_q.size() != 0 || joint_valid || pose_exp_q.size() != 0);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_angle();
		// favour angles near quadrant boundaries, where the residual is small
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 16) - 8);
		return 16'($urandom);
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) angle_q.push_back(rand_angle());
	endtask

	function automatic logic [30:0] rand_len();
		return ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
	endfunction

	initial begin
		logic [15:0] directed [24] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
			16'h2000, 16'h1FFF, 16'hE000, 16'hDFFF, 16'h6000, 16'h5FFF, 16'hA000,
			16'h0001, 16'h7FFF, 16'h8001, 16'h3FFF, 16'hBFFF, 16'h9FFF,
			16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h4001, 16'hC001};
		len_reg[REG_BASE_HEIGHT] = 31'd39322;
		len_reg[REG_LINK_THREE] = 31'd26214;
		len_reg[REG_LINK_FIVE] = 31'd13107;
		len_reg[REG_LINK_SIX] = 31'd6554;
		reset_pose();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) angle_q.push_back(directed[i]);
		drain();

		// full-scale links drive the translations into saturation
		write_all(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
		queue_random(30);
		drain();

		write_all('0, '0, '0, '0);
		queue_random(30);
		drain();

		write_all(rand_len(), rand_len(), rand_len(), rand_len());
		queue_random(150);
		drain();

		write_all(rand_len(), rand_len(), rand_len(), rand_len());
		calm = 1;
		queue_random(170);
		drain();

		if (fail_cnt == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule
